[hw/rtl/gn3_pkg.sv]
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
package gn3_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int BYTE_W     = 8;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int OUT_W      = 18;
    localparam int VAL_W      = 20;
    localparam int FADE_W     = FRAC_BITS + 1;
    localparam int POLY_W     = FRAC_BITS + 7;
    localparam int PROD_W     = VAL_W + FADE_W + 2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [BYTE_W-1:0]           byte_t;
    typedef logic [FRAC_BITS-1:0]        frac_t;
    typedef logic [FADE_W-1:0]           fade_t;
    typedef logic signed [VAL_W-1:0]     val_t;

    localparam fade_t FADE_ONE = fade_t'(1) << FRAC_BITS;
    localparam val_t  VAL_ONE  = val_t'(1) << FRAC_BITS;
    localparam val_t  OUT_HI   = val_t'((1 << (OUT_W - 1)) - 1);
    localparam val_t  OUT_LO   = -val_t'(1 << (OUT_W - 1));

    typedef struct packed {
        logic  en;
        logic  wr_en;
        idx_t  wr_addr;
        byte_t wr_data;
    } mem_ctl_t;

    function automatic frac_t frac_mul(input frac_t a, input frac_t b);
        logic [2*FRAC_BITS-1:0] p;
        p = {{FRAC_BITS{1'b0}}, a} * {{FRAC_BITS{1'b0}}, b};
        return p[2*FRAC_BITS-1:FRAC_BITS];
    endfunction

    function automatic fade_t fade(input frac_t t3, input frac_t t4, input frac_t t5);
        logic signed [POLY_W-1:0] a3;
        logic signed [POLY_W-1:0] a4;
        logic signed [POLY_W-1:0] a5;
        logic signed [POLY_W-1:0] s;
        a3 = POLY_W'(t3);
        a4 = POLY_W'(t4);
        a5 = POLY_W'(t5);
        s = POLY_W'(a5 * POLY_W'(6)) - POLY_W'(a4 * POLY_W'(15)) + POLY_W'(a3 * POLY_W'(10));
        if (s < 0)
        begin
            return '0;
        end
        else if (s > POLY_W'(FADE_ONE))
        begin
            return FADE_ONE;
        end
        return s[FADE_W-1:0];
    endfunction

    function automatic val_t corner_dot(input logic [3:0] k, input val_t dx, input val_t dy,
                                        input val_t dz);
        val_t p;
        val_t q;
        p = (k < 4'd8) ? dx : dy;
        if (k < 4'd4)
        begin
            q = dy;
        end
        else if (k == 4'd12 || k == 4'd14)
        begin
            q = dx;
        end
        else
        begin
            q = dz;
        end
        return (k[0] ? -p : p) + (k[1] ? -q : q);
    endfunction

    function automatic val_t blend(input fade_t w, input val_t a, input val_t b);
        logic signed [VAL_W:0]    d;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] sh;
        d  = (VAL_W+1)'(b) - (VAL_W+1)'(a);
        p  = $signed({1'b0, w}) * d;
        sh = p >>> FRAC_BITS;
        return a + sh[VAL_W-1:0];
    endfunction

endpackage

[hw/rtl/gn3_mem.sv]
// Permutation table copy: one write port, two registered read ports, identity reset.
module gn3_mem (
    input  logic             clk,
    input  logic             rst_n,
    input  gn3_pkg::mem_ctl_t ctl,
    input  gn3_pkg::idx_t    rd_addr0,
    input  gn3_pkg::idx_t    rd_addr1,
    output gn3_pkg::byte_t   rd_data0,
    output gn3_pkg::byte_t   rd_data1
);
    import gn3_pkg::*;

    byte_t                 mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] set_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg <= '0;
        end
        else if (ctl.en && ctl.wr_en)
        begin
            set_reg[ctl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rd_data0 <= set_reg[rd_addr0] ? mem[rd_addr0] : byte_t'(rd_addr0);
            rd_data1 <= set_reg[rd_addr1] ? mem[rd_addr1] : byte_t'(rd_addr1);
        end
    end

endmodule

[hw/rtl/gradient_noise_3d_top.sv]
// Top level of the pipelined 3D gradient noise evaluator.
//
// Input channel: in_valid/in_stall carry one word per cycle. func selects a
// table write (table_index, table_value) or a noise evaluation at the signed
// Q15.16 point (x_coord, y_coord, z_coord).
// Output channel: out_valid/out_stall carry noise_value, signed Q1.16, one word
// per evaluation; table writes give no word.
// Throughput: one word per cycle while out_stall does not hold the pipeline.
// The depth from acceptance to out_valid is set by three hash lookup levels in
// replicated table copies, the four chained fade multiplies and three blend multiply levels.
// A table write reaches each copy at the stage where that copy is read, so
// every evaluation sees exactly the writes accepted before it.
// Reset empties the pipeline and returns every table entry to the identity.
// When the receiver stalls a waiting word, the whole pipeline holds and
// in_stall rises; bubbles are not squeezed out.
module gradient_noise_3d_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic signed [gn3_pkg::COORD_W-1:0] x_coord,
    input  logic signed [gn3_pkg::COORD_W-1:0] y_coord,
    input  logic signed [gn3_pkg::COORD_W-1:0] z_coord,
    input  gn3_pkg::idx_t                     table_index,
    input  gn3_pkg::byte_t                    table_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [gn3_pkg::OUT_W-1:0]  noise_value
);
    import gn3_pkg::*;

    logic adv;
    logic [7:0] v_reg;
    logic [3:0] e_reg;
    logic out_valid_reg;

    idx_t  cx0_reg, cy0_reg, cz0_reg, cy1_reg, cz1_reg, cz2_reg;
    idx_t  widx_reg [3];
    byte_t wval_reg [3];
    frac_t t0_reg [3], t1_reg [3], t2_reg [3], t3_reg [3];
    frac_t sq1_reg [3], cu2_reg [3], cu3_reg [3], cu4_reg [3];
    frac_t qu3_reg [3], qu4_reg [3], qn4_reg [3];
    val_t  dot4_reg [8], dot5_reg [8];
    fade_t fade5_reg [3];
    fade_t fy6_reg, fz6_reg, fz7_reg;
    val_t  bx6_reg [4], by7_reg [2];
    logic signed [OUT_W-1:0] noise_reg;

    byte_t a_q0, a_q1, b0_q0, b0_q1, b1_q0, b1_q1;
    byte_t c_q0 [4], c_q1 [4];
    idx_t  ha, hb;
    idx_t  hc [4];
    mem_ctl_t ctl_a, ctl_b, ctl_c;
    val_t  dot_next [8];
    val_t  r_next, sat_next;
    logic  [COORD_W-1:0] coord [3];

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign coord[0] = x_coord;
    assign coord[1] = y_coord;
    assign coord[2] = z_coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[6:4], v_reg[3] && e_reg[3] == FUNC_EVAL, v_reg[2:0],
                              in_valid};
            e_reg         <= {e_reg[2:0], func};
            out_valid_reg <= v_reg[7];
        end
    end

    // table copies, each written in the stage that reads it
    assign ctl_a = '{en: adv, wr_en: v_reg[0] && e_reg[0] == FUNC_WRITE,
                     wr_addr: widx_reg[0], wr_data: wval_reg[0]};
    assign ctl_b = '{en: adv, wr_en: v_reg[1] && e_reg[1] == FUNC_WRITE,
                     wr_addr: widx_reg[1], wr_data: wval_reg[1]};
    assign ctl_c = '{en: adv, wr_en: v_reg[2] && e_reg[2] == FUNC_WRITE,
                     wr_addr: widx_reg[2], wr_data: wval_reg[2]};

    gn3_mem u_mem_a (.clk(clk), .rst_n(rst_n), .ctl(ctl_a), .rd_addr0(cx0_reg),
                     .rd_addr1(cx0_reg + idx_t'(1)), .rd_data0(a_q0), .rd_data1(a_q1));

    assign ha = idx_t'(a_q0) + cy1_reg;
    assign hb = idx_t'(a_q1) + cy1_reg;

    gn3_mem u_mem_b0 (.clk(clk), .rst_n(rst_n), .ctl(ctl_b), .rd_addr0(ha),
                      .rd_addr1(ha + idx_t'(1)), .rd_data0(b0_q0), .rd_data1(b0_q1));
    gn3_mem u_mem_b1 (.clk(clk), .rst_n(rst_n), .ctl(ctl_b), .rd_addr0(hb),
                      .rd_addr1(hb + idx_t'(1)), .rd_data0(b1_q0), .rd_data1(b1_q1));

    assign hc[0] = idx_t'(b0_q0) + cz2_reg;
    assign hc[1] = idx_t'(b0_q1) + cz2_reg;
    assign hc[2] = idx_t'(b1_q0) + cz2_reg;
    assign hc[3] = idx_t'(b1_q1) + cz2_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_mem_c
        gn3_mem u_mem_c (.clk(clk), .rst_n(rst_n), .ctl(ctl_c), .rd_addr0(hc[g]),
                         .rd_addr1(hc[g] + idx_t'(1)), .rd_data0(c_q0[g]),
                         .rd_data1(c_q1[g]));
    end

    // corner n: bit 0 takes x - 1, bit 1 takes y - 1, bit 2 takes z - 1
    always_comb
    begin
        val_t f [3];
        val_t gm [3];
        logic [3:0] k [8];
        for (int i = 0; i < 3; i++)
        begin
            f[i]  = val_t'(t3_reg[i]);
            gm[i] = val_t'(t3_reg[i]) - VAL_ONE;
        end
        k[0] = c_q0[0][3:0];
        k[4] = c_q1[0][3:0];
        k[2] = c_q0[1][3:0];
        k[6] = c_q1[1][3:0];
        k[1] = c_q0[2][3:0];
        k[5] = c_q1[2][3:0];
        k[3] = c_q0[3][3:0];
        k[7] = c_q1[3][3:0];
        for (int n = 0; n < 8; n++)
        begin
            dot_next[n] = corner_dot(k[n], n[0] ? gm[0] : f[0], n[1] ? gm[1] : f[1],
                                     n[2] ? gm[2] : f[2]);
        end
    end

    always_comb
    begin
        r_next = blend(fz7_reg, by7_reg[0], by7_reg[1]);
        if (r_next > OUT_HI)
        begin
            sat_next = OUT_HI;
        end
        else if (r_next < OUT_LO)
        begin
            sat_next = OUT_LO;
        end
        else
        begin
            sat_next = r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx0_reg     <= x_coord[FRAC_BITS+IDX_W-1:FRAC_BITS];
            cy0_reg     <= y_coord[FRAC_BITS+IDX_W-1:FRAC_BITS];
            cz0_reg     <= z_coord[FRAC_BITS+IDX_W-1:FRAC_BITS];
            cy1_reg     <= cy0_reg;
            cz1_reg     <= cz0_reg;
            cz2_reg     <= cz1_reg;
            widx_reg[0] <= table_index;
            wval_reg[0] <= table_value;
            widx_reg[1] <= widx_reg[0];
            wval_reg[1] <= wval_reg[0];
            widx_reg[2] <= widx_reg[1];
            wval_reg[2] <= wval_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                t0_reg[i]    <= coord[i][FRAC_BITS-1:0];
                t1_reg[i]    <= t0_reg[i];
                t2_reg[i]    <= t1_reg[i];
                t3_reg[i]    <= t2_reg[i];
                sq1_reg[i]   <= frac_mul(t0_reg[i], t0_reg[i]);
                cu2_reg[i]   <= frac_mul(sq1_reg[i], t1_reg[i]);
                cu3_reg[i]   <= cu2_reg[i];
                qu3_reg[i]   <= frac_mul(cu2_reg[i], t2_reg[i]);
                cu4_reg[i]   <= cu3_reg[i];
                qu4_reg[i]   <= qu3_reg[i];
                qn4_reg[i]   <= frac_mul(qu3_reg[i], t3_reg[i]);
                fade5_reg[i] <= fade(cu4_reg[i], qu4_reg[i], qn4_reg[i]);
            end
            for (int n = 0; n < 8; n++)
            begin
                dot4_reg[n] <= dot_next[n];
                dot5_reg[n] <= dot4_reg[n];
            end
            for (int j = 0; j < 4; j++)
            begin
                bx6_reg[j] <= blend(fade5_reg[0], dot5_reg[2*j], dot5_reg[2*j+1]);
            end
            fy6_reg    <= fade5_reg[1];
            fz6_reg    <= fade5_reg[2];
            by7_reg[0] <= blend(fy6_reg, bx6_reg[0], bx6_reg[1]);
            by7_reg[1] <= blend(fy6_reg, bx6_reg[2], bx6_reg[3]);
            fz7_reg    <= fz6_reg;
            noise_reg  <= sat_next[OUT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    a_write_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && e_reg[3] == FUNC_WRITE && adv) |=> !v_reg[4])
        else $error("table write reached the blend stages");

    a_eval_word: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[7] && adv) |=> out_valid)
        else $error("evaluation lost at the output register");

    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] |-> (fade5_reg[0] <= FADE_ONE && fade5_reg[1] <= FADE_ONE &&
                      fade5_reg[2] <= FADE_ONE))
        else $error("fade weight out of range");

endmodule
